// ===== sv/refcounted_buffer_pool_defines.svh =====
// Assertion macros for the reference-counted buffer pool.
// Included by the top level; no other dependencies.
`ifndef REFCOUNTED_BUFFER_POOL_DEFINES_SVH
`define REFCOUNTED_BUFFER_POOL_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define RCBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcbp check failed");
// Next-cycle implication, disabled while in reset.
`define RCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcbp check failed");
`else
`define RCBP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rcbp_pkg.sv =====
// Shared types and codes for the reference-counted buffer pool.
// No dependencies.
package rcbp_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned HOFF_W   = 17;
  localparam int unsigned ROFF_W   = 18;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 8;
  localparam logic [LEN_W-1:0] BUFFER_SIZE_RESET = 16'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_SHARE = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_WINDOW     = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_NOT_IN_USE = 3'd4,
    ST_COUNT_FULL = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input word and launch the count read
    logic execute;  // resolve the command, write back, load the result
  } ctrl_t;

endpackage

// ===== sv/rcbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/rcbp_ctrl.sv =====
// Command sequencer for the buffer pool: capture, then execute.
// Depends on rcbp_pkg.
module rcbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output rcbp_pkg::ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.execute = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sv/rcbp_dp.sv =====
// Datapath of the buffer pool: input word latch, use-count store with valid
// bits, round-robin pointer, checks and result register. Depends on rcbp_pkg, rcbp_ram.
module rcbp_dp #(
  parameter int unsigned NUM_BUFFERS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rcbp_pkg::ctrl_t                   ctrl,
  input  logic                              cfg_wr_en,
  input  logic [rcbp_pkg::LEN_W-1:0]        cfg_wr_data,
  input  logic [rcbp_pkg::CMD_W-1:0]        in_cmd,
  input  logic [rcbp_pkg::LEN_W-1:0]        in_msg_len,
  input  logic [rcbp_pkg::LEN_W-1:0]        in_offset,
  input  logic [rcbp_pkg::SLOT_W-1:0]       in_buffer_no,
  input  logic [rcbp_pkg::LEN_W-1:0]        in_handle_length,
  input  logic [rcbp_pkg::HOFF_W-1:0]       in_handle_offset,
  input  logic                              in_handle_valid,
  output logic                              out_strobe,
  output logic [rcbp_pkg::STATUS_W-1:0]     out_status,
  output logic [rcbp_pkg::SLOT_W-1:0]       out_slot,
  output logic [rcbp_pkg::ROFF_W-1:0]       out_result_offset,
  output logic [rcbp_pkg::LEN_W-1:0]        out_result_length
);

  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS);
  localparam int unsigned LEN_W = rcbp_pkg::LEN_W;
  localparam int unsigned CNT_W = rcbp_pkg::COUNT_W;

  // Configuration
  logic [LEN_W-1:0] buffer_size_r;

  // Latched input word
  logic [rcbp_pkg::CMD_W-1:0]  cmd_r;
  logic [LEN_W-1:0]            msg_len_r;
  logic [LEN_W-1:0]            offset_r;
  logic [rcbp_pkg::SLOT_W-1:0] buffer_no_r;
  logic [LEN_W-1:0]            handle_length_r;
  logic [rcbp_pkg::HOFF_W-1:0] handle_offset_r;
  logic                        handle_valid_r;

  // Count store
  logic [NUM_BUFFERS-1:0] vld_r;
  logic                   vld_hit_r;
  logic [CNT_W-1:0]       rd_count;
  logic [CNT_W-1:0]       count;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [CNT_W-1:0]       wr_data;

  logic [IDX_W-1:0] next_slot_r, next_slot_nxt;

  // Result
  logic                          strobe_r;
  logic [rcbp_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [rcbp_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [rcbp_pkg::ROFF_W-1:0]   roff_r, roff_nxt;
  logic [LEN_W-1:0]              rlen_r, rlen_nxt;

  logic [LEN_W:0]               alloc_end;
  logic [LEN_W:0]               window_end;
  logic                         in_range;
  logic                         upd_en;

  rcbp_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NUM_BUFFERS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.capture),
    .rd_addr (in_buffer_no[IDX_W-1:0]),
    .rd_data (rd_count)
  );

  // Never-written slots read as zero.
  assign count = vld_hit_r ? rd_count : '0;

  assign alloc_end  = {1'b0, msg_len_r} + {1'b0, offset_r};
  assign window_end = {1'b0, offset_r} + {1'b0, msg_len_r};
  assign in_range   = ({1'b0, buffer_no_r} < (rcbp_pkg::SLOT_W + 1)'(NUM_BUFFERS));

  always_comb begin
    status_nxt    = rcbp_pkg::ST_BAD_HANDLE;
    slot_nxt      = '0;
    roff_nxt      = '0;
    rlen_nxt      = '0;
    upd_en        = 1'b0;
    wr_addr       = buffer_no_r[IDX_W-1:0];
    wr_data       = count;
    next_slot_nxt = next_slot_r;
    unique case (cmd_r)
      rcbp_pkg::CMD_ALLOC: begin
        if (alloc_end > {1'b0, buffer_size_r}) begin
          status_nxt = rcbp_pkg::ST_TOO_LONG;
        end else begin
          status_nxt    = rcbp_pkg::ST_OK;
          slot_nxt      = rcbp_pkg::SLOT_W'(next_slot_r);
          roff_nxt      = rcbp_pkg::ROFF_W'(offset_r);
          rlen_nxt      = msg_len_r;
          upd_en        = 1'b1;
          wr_addr       = next_slot_r;
          wr_data       = CNT_W'(1);
          next_slot_nxt = (next_slot_r == IDX_W'(NUM_BUFFERS - 1)) ? '0
                                                                  : next_slot_r + IDX_W'(1);
        end
      end
      rcbp_pkg::CMD_SHARE: begin
        if (window_end > {1'b0, handle_length_r}) begin
          status_nxt = rcbp_pkg::ST_WINDOW;
        end else if (!in_range) begin
          status_nxt = rcbp_pkg::ST_BAD_HANDLE;
        end else if (count == {CNT_W{1'b1}}) begin
          status_nxt = rcbp_pkg::ST_COUNT_FULL;
        end else begin
          status_nxt = rcbp_pkg::ST_OK;
          slot_nxt   = buffer_no_r;
          roff_nxt   = rcbp_pkg::ROFF_W'(handle_offset_r) + rcbp_pkg::ROFF_W'(offset_r);
          rlen_nxt   = msg_len_r;
          upd_en     = 1'b1;
          wr_data    = count + CNT_W'(1);
        end
      end
      rcbp_pkg::CMD_FREE: begin
        if (!handle_valid_r || !in_range) begin
          status_nxt = rcbp_pkg::ST_BAD_HANDLE;
        end else if (count == '0) begin
          status_nxt = rcbp_pkg::ST_NOT_IN_USE;
        end else begin
          status_nxt = rcbp_pkg::ST_OK;
          upd_en     = 1'b1;
          wr_data    = count - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = rcbp_pkg::ST_BAD_HANDLE;
      end
    endcase
  end

  assign wr_en = ctrl.execute && upd_en;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= rcbp_pkg::BUFFER_SIZE_RESET;
      vld_r         <= '0;
      next_slot_r   <= '0;
      strobe_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        buffer_size_r <= cfg_wr_data;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctrl.execute) begin
        next_slot_r <= next_slot_nxt;
      end
      strobe_r <= ctrl.execute;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r           <= in_cmd;
      msg_len_r       <= in_msg_len;
      offset_r        <= in_offset;
      buffer_no_r     <= in_buffer_no;
      handle_length_r <= in_handle_length;
      handle_offset_r <= in_handle_offset;
      handle_valid_r  <= in_handle_valid;
      vld_hit_r       <= vld_r[in_buffer_no[IDX_W-1:0]];
    end
    if (ctrl.execute) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      roff_r   <= roff_nxt;
      rlen_r   <= rlen_nxt;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_result_offset = roff_r;
  assign out_result_length = rlen_r;

endmodule

// ===== sv/refcounted_buffer_pool.sv =====
// Reference-counted buffer pool: top level tying the controller to the datapath.
// Depends on rcbp_pkg, rcbp_ctrl, rcbp_dp and refcounted_buffer_pool_defines.svh.
//
// Use:
//   Drive a command word (allocate, share or free) on the in_ ports and raise
//   start. The word is taken at a rising edge with start high and busy low.
//   busy then stays high for one cycle while the slot's use count is read
//   from the count RAM and written back.
//   Exactly one result word follows per command: out_strobe is high for one
//   cycle, starting the cycle after the command is resolved. The registered
//   read of the count RAM is followed by its write-back, and busy stays high
//   until that write-back, so a new command waits for it. The result register
//   is independent of the sequencer, so a new command is taken while the
//   previous result is on the out_ ports. The receiver cannot stall: each
//   result is shown once and then replaced. The user must write buffer_size
//   through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
//   Reset (rst_n low, synchronous) zeroes every use count at once through
//   per-slot valid bits, rewinds the round-robin pointer to slot 0 and sets
//   buffer_size to 4096. No clearing pass is needed.
`include "refcounted_buffer_pool_defines.svh"

module refcounted_buffer_pool #(
  parameter int unsigned NUM_BUFFERS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration
  input  logic                          cfg_wr_en,
  input  logic [rcbp_pkg::LEN_W-1:0]    cfg_wr_data,
  // Command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [rcbp_pkg::CMD_W-1:0]    in_cmd,
  input  logic [rcbp_pkg::LEN_W-1:0]    in_msg_len,
  input  logic [rcbp_pkg::LEN_W-1:0]    in_offset,
  input  logic [rcbp_pkg::SLOT_W-1:0]   in_buffer_no,
  input  logic [rcbp_pkg::LEN_W-1:0]    in_handle_length,
  input  logic [rcbp_pkg::HOFF_W-1:0]   in_handle_offset,
  input  logic                          in_handle_valid,
  // Result channel
  output logic                          out_strobe,
  output logic [rcbp_pkg::STATUS_W-1:0] out_status,
  output logic [rcbp_pkg::SLOT_W-1:0]   out_slot,
  output logic [rcbp_pkg::ROFF_W-1:0]   out_result_offset,
  output logic [rcbp_pkg::LEN_W-1:0]    out_result_length
);

  // Capture and execute commands from the sequencer.
  rcbp_pkg::ctrl_t ctrl;

  rcbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Hold the count store, pointer, checks and the result register.
  rcbp_dp #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_cmd            (in_cmd),
    .in_msg_len        (in_msg_len),
    .in_offset         (in_offset),
    .in_buffer_no      (in_buffer_no),
    .in_handle_length  (in_handle_length),
    .in_handle_offset  (in_handle_offset),
    .in_handle_valid   (in_handle_valid),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_result_offset (out_result_offset),
    .out_result_length (out_result_length)
  );

  // An accepted word must lock out the next one for a cycle.
  `RCBP_ASSERT_NEXT(a_accept_sets_busy, clk, rst_n, start && !busy, busy)
  // A result word appears only after an accepted command word.
  `RCBP_ASSERT_SAME(a_result_follows_accept, clk, rst_n, out_strobe, $past(start && !busy, 2))
  // Refused commands carry no handle.
  `RCBP_ASSERT_SAME(a_refusal_zero_fields, clk, rst_n, out_strobe && (out_status != rcbp_pkg::ST_OK), (out_slot == '0) && (out_result_offset == '0) && (out_result_length == '0))

endmodule
